[src/ctc_pkg.sv]
// Shared types and constants for the calibrated tag combiner.
// Depends on nothing; every other file imports it.
package ctc_pkg;

	// Fixed-point format of all mistag values.
	localparam int FRAC_BITS  = 16;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int HALF       = ONE / 2;
	localparam int OS_AVG_ETA = 24000;
	localparam int SS_AVG_ETA = 24000;

	// Configuration registers.
	localparam int NUM_REGS = 8;
	localparam int REG_W    = 18;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int IDX_W    = $clog2(NUM_REGS);

	// Datapath widths.
	localparam int ETA_W  = 16;
	localparam int DIFF_W = ETA_W + 1;
	localparam int PROD_W = REG_W + DIFF_W;
	localparam int CAL_W  = 20;
	localparam int PM_W   = FRAC_BITS + 1;
	localparam int BP_W   = 2 * FRAC_BITS + 1;
	localparam int R_W    = BP_W + 1;
	localparam int Q_W    = FRAC_BITS + 2;
	localparam int RAT_W  = Q_W - 1;
	localparam int DEL_W  = 17;

	// Divider stages: one initial compare, then one quotient bit per stage.
	localparam int DIV_STAGES = FRAC_BITS + 2;

	// Decision codes.
	localparam logic signed [1:0] DEC_NONE  = 2'sb00;
	localparam logic signed [1:0] DEC_PLUS  = 2'sb01;
	localparam logic signed [1:0] DEC_MINUS = 2'sb11;

	typedef enum logic [IDX_W-1:0] {
		REG_OS_AVG_OFFSET   = 3'd0,
		REG_OS_AVG_SLOPE    = 3'd1,
		REG_OS_DELTA_OFFSET = 3'd2,
		REG_OS_DELTA_SLOPE  = 3'd3,
		REG_SS_AVG_OFFSET   = 3'd4,
		REG_SS_AVG_SLOPE    = 3'd5,
		REG_SS_DELTA_OFFSET = 3'd6,
		REG_SS_DELTA_SLOPE  = 3'd7
	} reg_idx_t;

	localparam logic signed [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
		18'sd24000, 18'sd65536, 18'sd0, 18'sd0,
		18'sd24000, 18'sd65536, 18'sd0, 18'sd0
	};

	// Bayes combination mode for two firing taggers.
	typedef enum logic [1:0] {
		MODE_AGREE  = 2'b00,
		MODE_KEEP_A = 2'b01,
		MODE_KEEP_B = 2'b10
	} mode_t;

	// Result fields that travel beside the division.
	typedef struct packed {
		logic                    both;
		logic signed [1:0]       dec;
		logic [ETA_W-1:0]        avg;
		logic signed [DEL_W-1:0] del;
	} side_t;

endpackage

[src/ctc_if.sv]
// Channel interfaces of the calibrated tag combiner: tag items in, results out.
// Depends on ctc_pkg for field widths.
interface ctc_tag_if
	import ctc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [1:0]       os_decision;
	logic signed [1:0]       ss_decision;
	logic [ETA_W-1:0]        os_eta;
	logic [ETA_W-1:0]        ss_eta;

	modport source(output valid, os_decision, ss_decision, os_eta, ss_eta, input ready);
	modport sink(input valid, os_decision, ss_decision, os_eta, ss_eta, output ready);
endinterface

interface ctc_result_if
	import ctc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [1:0]       combined_decision;
	logic [ETA_W-1:0]        average_mistag;
	logic signed [DEL_W-1:0] mistag_difference;

	modport source(output valid, combined_decision, average_mistag, mistag_difference,
		input ready);
	modport sink(input valid, combined_decision, average_mistag, mistag_difference,
		output ready);
endinterface

[src/calibrated_tag_combiner.sv]
// Top level of the calibrated tag combiner: calibration, Bayes combination, output.
// Depends on ctc_pkg, ctc_if and ctc_div_pipe.
//
// Channel   Kind        Width            Contents
// tag       sink        2+2+16+16 bits   tagger decisions and raw mistag estimates
// result    source      2+16+17 bits     combined decision, average mistag, difference
// apb       config      5-bit address    eight 18-bit calibration registers at 4*i
//
// One item enters per cycle while the output is not stalled; each transfer passes through
// four calibration and product stages, the 18 stages of the divider (one quotient
// bit each), and the output register. Reset clears all valid bits and loads the
// register defaults. A stall holds each full stage; empty stages ahead of a stall
// still fill, so input is taken while a result waits.
module calibrated_tag_combiner
	import ctc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	ctc_tag_if.sink            tag,
	ctc_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic signed [REG_W-1:0] cfg_q [NUM_REGS];
	logic [IDX_W-1:0]        cfg_idx;

	// Stage 1: decisions and slope products.
	logic                     v_s1, en_s1;
	logic signed [1:0]        dos_s1, dss_s1;
	logic signed [PROD_W-1:0] poa_s1, pod_s1, psa_s1, psd_s1;
	logic signed [DIFF_W-1:0] os_diff, ss_diff;

	// Stage 2: calibrated values and mode.
	logic                     v_s2, en_s2;
	logic signed [CAL_W-1:0]  m1_s2, d1_s2, m2_s2, d2_s2;
	logic signed [CAL_W-1:0]  m1, d1, m2, d2;
	mode_t                    mode_s2, mode_c;
	side_t                    side_s2, side_c;

	// Stage 3: plus and minus mistags.
	logic                     v_s3, en_s3;
	logic [PM_W-1:0]          wp1_s3, wp2_s3, wm1_s3, wm2_s3;
	mode_t                    mode_s3;
	side_t                    side_s3;

	// Stage 4: Bayes products.
	logic                     v_s4, en_s4;
	logic [BP_W-1:0]          abp_s4, nnp_s4, anp_s4, nap_s4;
	logic [BP_W-1:0]          abm_s4, nnm_s4, anm_s4, nam_s4;
	mode_t                    mode_s4;
	side_t                    side_s4;
	logic [BP_W-1:0]          num_p, den_p, num_m, den_m;

	// Divider and output stage.
	logic                     div_in_ready, div_out_valid;
	logic [RAT_W-1:0]         cp, cm;
	side_t                    div_side;
	logic                     v_s5, en_s5;
	logic signed [1:0]        dec_s5;
	logic [ETA_W-1:0]         avg_s5;
	logic signed [DEL_W-1:0]  del_s5;
	logic                     both_s5;
	logic [RAT_W:0]           avg_sum;
	logic [RAT_W-1:0]         avg_b;
	logic signed [RAT_W:0]    del_b;

	function automatic logic signed [1:0] norm_dec(input logic signed [1:0] d);
		if (d == DEC_NONE) begin
			norm_dec = DEC_NONE;
		end else if (d[1]) begin
			norm_dec = DEC_MINUS;
		end else begin
			norm_dec = DEC_PLUS;
		end
	endfunction

	// Offset plus slope product rounded half up at the binary point.
	function automatic logic signed [CAL_W-1:0] cal_fn(input logic signed [REG_W-1:0] off,
		input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(HALF);
		cal_fn = CAL_W'(off) + CAL_W'(signed'(t[PROD_W-1:FRAC_BITS]));
	endfunction

	function automatic logic [ETA_W-1:0] sat_avg(input logic signed [CAL_W-1:0] v);
		if (v < 0) begin
			sat_avg = '0;
		end else if (v > CAL_W'(ONE - 1)) begin
			sat_avg = '1;
		end else begin
			sat_avg = v[ETA_W-1:0];
		end
	endfunction

	function automatic logic signed [DEL_W-1:0] sat_del(input logic signed [CAL_W-1:0] v);
		if (v < -CAL_W'(ONE)) begin
			sat_del = -DEL_W'(ONE);
		end else if (v > CAL_W'(ONE - 1)) begin
			sat_del = DEL_W'(ONE - 1);
		end else begin
			sat_del = v[DEL_W-1:0];
		end
	endfunction

	// Half of (2m +/- d), rounded half up, saturated into [0, ONE].
	function automatic logic [PM_W-1:0] pm_fn(input logic signed [CAL_W-1:0] m,
		input logic signed [CAL_W-1:0] d, input logic plus);
		logic signed [CAL_W+1:0] v;
		logic signed [CAL_W+1:0] t;
		v = plus ? ((CAL_W+2)'(m) <<< 1) + (CAL_W+2)'(d)
		         : ((CAL_W+2)'(m) <<< 1) - (CAL_W+2)'(d);
		t = (v + (CAL_W+2)'(1)) >>> 1;
		if (t < 0) begin
			pm_fn = '0;
		end else if (t > (CAL_W+2)'(ONE)) begin
			pm_fn = PM_W'(ONE);
		end else begin
			pm_fn = t[PM_W-1:0];
		end
	endfunction

	function automatic logic [BP_W-1:0] mul_fn(input logic [PM_W-1:0] a,
		input logic [PM_W-1:0] b);
		logic [2*PM_W-1:0] p;
		p = a * b;
		mul_fn = p[BP_W-1:0];
	endfunction

	// Configuration registers, written on the access phase of an APB transfer.
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = DATA_W'(cfg_q[cfg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[cfg_idx] <= signed'(pwdata[REG_W-1:0]);
		end
	end

	// Elastic stage enables, from the output back to the input.
	assign en_s5 = !v_s5 || result.ready;
	assign en_s4 = !v_s4 || div_in_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign tag.ready = en_s1;

	// Stage 1: center the estimates and multiply by the slopes.
	assign os_diff = signed'({1'b0, tag.os_eta}) - DIFF_W'(OS_AVG_ETA);
	assign ss_diff = signed'({1'b0, tag.ss_eta}) - DIFF_W'(SS_AVG_ETA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= tag.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dos_s1 <= norm_dec(tag.os_decision);
			dss_s1 <= norm_dec(tag.ss_decision);
			poa_s1 <= PROD_W'(cfg_q[REG_OS_AVG_SLOPE]) * PROD_W'(os_diff);
			pod_s1 <= PROD_W'(cfg_q[REG_OS_DELTA_SLOPE]) * PROD_W'(os_diff);
			psa_s1 <= PROD_W'(cfg_q[REG_SS_AVG_SLOPE]) * PROD_W'(ss_diff);
			psd_s1 <= PROD_W'(cfg_q[REG_SS_DELTA_SLOPE]) * PROD_W'(ss_diff);
		end
	end

	// Stage 2: add offsets, settle single-tagger results and the Bayes mode.
	assign m1 = cal_fn(cfg_q[REG_OS_AVG_OFFSET], poa_s1);
	assign d1 = cal_fn(cfg_q[REG_OS_DELTA_OFFSET], pod_s1);
	assign m2 = cal_fn(cfg_q[REG_SS_AVG_OFFSET], psa_s1);
	assign d2 = cal_fn(cfg_q[REG_SS_DELTA_OFFSET], psd_s1);

	always_comb begin
		side_c = '0;
		mode_c = MODE_AGREE;
		priority if (dos_s1 == DEC_NONE && dss_s1 == DEC_NONE) begin
			side_c.dec = DEC_NONE;
			side_c.avg = ETA_W'(HALF);
		end else if (dss_s1 == DEC_NONE) begin
			side_c.dec = dos_s1;
			side_c.avg = sat_avg(m1);
			side_c.del = sat_del(d1);
		end else if (dos_s1 == DEC_NONE) begin
			side_c.dec = dss_s1;
			side_c.avg = sat_avg(m2);
			side_c.del = sat_del(d2);
		end else begin
			side_c.both = 1'b1;
			if (dos_s1 == dss_s1) begin
				side_c.dec = dos_s1;
				mode_c     = MODE_AGREE;
			end else if (m1 < m2) begin
				side_c.dec = dos_s1;
				mode_c     = MODE_KEEP_A;
			end else begin
				side_c.dec = dss_s1;
				mode_c     = MODE_KEEP_B;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			m1_s2   <= m1;
			d1_s2   <= d1;
			m2_s2   <= m2;
			d2_s2   <= d2;
			mode_s2 <= mode_c;
			side_s2 <= side_c;
		end
	end

	// Stage 3: plus and minus mistags of both taggers.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			wp1_s3  <= pm_fn(m1_s2, d1_s2, 1'b1);
			wp2_s3  <= pm_fn(m2_s2, d2_s2, 1'b1);
			wm1_s3  <= pm_fn(m1_s2, d1_s2, 1'b0);
			wm2_s3  <= pm_fn(m2_s2, d2_s2, 1'b0);
			mode_s3 <= mode_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: the four Bayes products for each lane.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			abp_s4  <= mul_fn(wp1_s3, wp2_s3);
			nnp_s4  <= mul_fn(PM_W'(ONE) - wp1_s3, PM_W'(ONE) - wp2_s3);
			anp_s4  <= mul_fn(wp1_s3, PM_W'(ONE) - wp2_s3);
			nap_s4  <= mul_fn(PM_W'(ONE) - wp1_s3, wp2_s3);
			abm_s4  <= mul_fn(wm1_s3, wm2_s3);
			nnm_s4  <= mul_fn(PM_W'(ONE) - wm1_s3, PM_W'(ONE) - wm2_s3);
			anm_s4  <= mul_fn(wm1_s3, PM_W'(ONE) - wm2_s3);
			nam_s4  <= mul_fn(PM_W'(ONE) - wm1_s3, wm2_s3);
			mode_s4 <= mode_s3;
			side_s4 <= side_s3;
		end
	end

	// Numerator and denominator selection; the sums never exceed ONE squared.
	always_comb begin
		unique case (mode_s4)
			MODE_AGREE: begin
				num_p = abp_s4;
				den_p = abp_s4 + nnp_s4;
				num_m = abm_s4;
				den_m = abm_s4 + nnm_s4;
			end
			MODE_KEEP_A: begin
				num_p = anp_s4;
				den_p = anp_s4 + nap_s4;
				num_m = anm_s4;
				den_m = anm_s4 + nam_s4;
			end
			MODE_KEEP_B: begin
				num_p = nap_s4;
				den_p = anp_s4 + nap_s4;
				num_m = nam_s4;
				den_m = anm_s4 + nam_s4;
			end
			default: begin
				num_p = '0;
				den_p = '0;
				num_m = '0;
				den_m = '0;
			end
		endcase
	end

	ctc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.num_p     (num_p),
		.den_p     (den_p),
		.num_m     (num_m),
		.den_m     (den_m),
		.in_side   (side_s4),
		.out_valid (div_out_valid),
		.out_ready (en_s5),
		.ratio_p   (cp),
		.ratio_m   (cm),
		.out_side  (div_side)
	);

	// Output stage: two-tagger average and difference of the lanes, mirrored above one half.
	assign avg_sum = {1'b0, cp} + {1'b0, cm} + (RAT_W+1)'(1);
	assign avg_b   = avg_sum[RAT_W:1];
	assign del_b   = signed'({1'b0, cp}) - signed'({1'b0, cm});

	always_ff @(posedge clk) begin
		if (en_s5) begin
			both_s5 <= div_side.both;
			if (!div_side.both) begin
				dec_s5 <= div_side.dec;
				avg_s5 <= div_side.avg;
				del_s5 <= div_side.del;
			end else begin
				if (avg_b > RAT_W'(HALF)) begin
					avg_s5 <= ETA_W'(RAT_W'(ONE) - avg_b);
					dec_s5 <= DEC_NONE - div_side.dec;
				end else begin
					avg_s5 <= avg_b[ETA_W-1:0];
					dec_s5 <= div_side.dec;
				end
				del_s5 <= (del_b > (RAT_W+1)'(ONE - 1)) ? DEL_W'(ONE - 1) : del_b[DEL_W-1:0];
			end
		end
	end

	assign result.valid             = v_s5;
	assign result.combined_decision = dec_s5;
	assign result.average_mistag    = avg_s5;
	assign result.mistag_difference = del_s5;

	// An empty first stage always takes a transfer.
	assert property (@(posedge clk) disable iff (!arst_n) !v_s1 |-> tag.ready)
		else $error("input not ready while first stage is empty");

	// An accepted transfer occupies the first stage on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n) (tag.valid && tag.ready) |=> v_s1)
		else $error("accepted transfer lost at first stage");

	// A stalled result is not dropped.
	assert property (@(posedge clk) disable iff (!arst_n) (v_s5 && !result.ready) |=> v_s5)
		else $error("stalled result dropped");

	// A two-tagger result is mirrored into the lower half.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && both_s5) |-> (avg_s5 <= ETA_W'(HALF)))
		else $error("combined average above one half");

endmodule

[src/ctc_div_pipe.sv]
// Two-lane pipelined restoring divider giving round(num / den * ONE).
// Depends on ctc_pkg; one quotient bit is resolved in each stage.
module ctc_div_pipe
	import ctc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BP_W-1:0]   num_p,
	input  logic [BP_W-1:0]   den_p,
	input  logic [BP_W-1:0]   num_m,
	input  logic [BP_W-1:0]   den_m,
	input  side_t             in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RAT_W-1:0]  ratio_p,
	output logic [RAT_W-1:0]  ratio_m,
	output side_t             out_side
);

	logic              v_q     [DIV_STAGES];
	logic              en      [DIV_STAGES];
	logic [R_W-1:0]    rp_q    [DIV_STAGES];
	logic [R_W-1:0]    rm_q    [DIV_STAGES];
	logic [Q_W-1:0]    qp_q    [DIV_STAGES];
	logic [Q_W-1:0]    qm_q    [DIV_STAGES];
	logic [BP_W-1:0]   denp_q  [DIV_STAGES];
	logic [BP_W-1:0]   denm_q  [DIV_STAGES];
	logic              zp_q    [DIV_STAGES];
	logic              zm_q    [DIV_STAGES];
	side_t             side_q  [DIV_STAGES];
	logic [Q_W:0]      qp_round;
	logic [Q_W:0]      qm_round;

	// One restoring step: shift the remainder, subtract when it fits.
	function automatic logic [R_W:0] div_step(input logic [R_W-1:0] r,
		input logic [BP_W-1:0] den);
		logic [R_W-1:0] r2;
		logic [R_W-1:0] d;
		r2 = {r[R_W-2:0], 1'b0};
		d  = R_W'(den);
		if (r2 >= d) begin
			div_step = {1'b1, r2 - d};
		end else begin
			div_step = {1'b0, r2};
		end
	endfunction

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		// A stage loads when it is empty or its successor moves on.
		if (k == DIV_STAGES - 1) begin : g_last
			assign en[k] = !v_q[k] || out_ready;
		end else begin : g_mid
			assign en[k] = !v_q[k] || en[k+1];
		end

		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (en[k]) begin
					v_q[k] <= in_valid;
				end
			end

			// Leading quotient bit is set when the numerator is at least the denominator.
			always_ff @(posedge clk) begin
				if (en[k]) begin
					qp_q[k]   <= Q_W'(num_p >= den_p);
					qm_q[k]   <= Q_W'(num_m >= den_m);
					rp_q[k]   <= (num_p >= den_p) ? R_W'(num_p - den_p) : R_W'(num_p);
					rm_q[k]   <= (num_m >= den_m) ? R_W'(num_m - den_m) : R_W'(num_m);
					denp_q[k] <= den_p;
					denm_q[k] <= den_m;
					zp_q[k]   <= (den_p == '0);
					zm_q[k]   <= (den_m == '0);
					side_q[k] <= in_side;
				end
			end
		end else begin : g_iter
			logic [R_W:0] sp;
			logic [R_W:0] sm;
			assign sp = div_step(rp_q[k-1], denp_q[k-1]);
			assign sm = div_step(rm_q[k-1], denm_q[k-1]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					qp_q[k]   <= {qp_q[k-1][Q_W-2:0], sp[R_W]};
					qm_q[k]   <= {qm_q[k-1][Q_W-2:0], sm[R_W]};
					rp_q[k]   <= sp[R_W-1:0];
					rm_q[k]   <= sm[R_W-1:0];
					denp_q[k] <= denp_q[k-1];
					denm_q[k] <= denm_q[k-1];
					zp_q[k]   <= zp_q[k-1];
					zm_q[k]   <= zm_q[k-1];
					side_q[k] <= side_q[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];

	// Round the quotient half up; a zero denominator gives one half.
	assign qp_round = {1'b0, qp_q[DIV_STAGES-1]} + (Q_W+1)'(1);
	assign qm_round = {1'b0, qm_q[DIV_STAGES-1]} + (Q_W+1)'(1);
	assign ratio_p  = zp_q[DIV_STAGES-1] ? RAT_W'(HALF) : qp_round[Q_W-1:1];
	assign ratio_m  = zm_q[DIV_STAGES-1] ? RAT_W'(HALF) : qm_round[Q_W-1:1];
	assign out_side = side_q[DIV_STAGES-1];
	assign out_valid = v_q[DIV_STAGES-1];

endmodule
